[hw/rtl/qmh_pkg.sv]
// ---------------------------------------------------------------------------
// qmh_pkg
// Shared types and codes for the quaternary min-heap queue.
// ---------------------------------------------------------------------------
package qmh_pkg;

  // Commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // Result item handed from the core to the output register
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] min_key;
    logic [7:0]  min_handle;
    logic [8:0]  count;
    logic        empty_res;
  } res_t;

  // Control of the best-child tracker
  typedef struct packed {
    logic load;
    logic first;
  } trk_ctl_t;

endpackage

[hw/rtl/qmh_if.sv]
// ---------------------------------------------------------------------------
// qmh_req_if / qmh_res_if
// Valid/ready channels carrying operations in and results out.
// ---------------------------------------------------------------------------
interface qmh_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] key;
  logic [7:0]  handle;

  modport source (output valid, command, key, handle, input ready);
  modport sink   (input valid, command, key, handle, output ready);
endinterface

interface qmh_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] min_key;
  logic [7:0]  min_handle;
  logic [8:0]  count;
  logic        empty_res;

  modport source (output valid, status, min_key, min_handle, count, empty_res, input ready);
  modport sink   (input valid, status, min_key, min_handle, count, empty_res, output ready);
endinterface

[hw/rtl/qmh_best.sv]
// ---------------------------------------------------------------------------
// qmh_best
// Shared compare unit: tracks the least of the children streamed in, one per
// cycle, keeping the earliest on equal keys.
// ---------------------------------------------------------------------------
module qmh_best
  import qmh_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int AW       = 8
) (
  input  logic                clk,
  input  trk_ctl_t            ctl,
  input  logic [KEY_BITS-1:0] key,
  input  logic [7:0]          hnd,
  input  logic [AW-1:0]       idx,
  output logic [KEY_BITS-1:0] best_key,
  output logic [7:0]          best_hnd,
  output logic [AW-1:0]       best_idx
);

  // Strict less-than keeps the earliest least child
  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.first || (key < best_key))) begin
      best_key <= key;
      best_hnd <= hnd;
      best_idx <= idx;
    end
  end

endmodule

[hw/rtl/qmh_core.sv]
// ---------------------------------------------------------------------------
// qmh_core
// Heap storage, position table and the sequencer that runs insert, delete,
// sift up and sift down one memory access per cycle.
// ---------------------------------------------------------------------------
module qmh_core
  import qmh_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                cmd,
  input  logic [KEY_BITS-1:0] key,
  input  logic [7:0]          handle,
  output logic                idle,
  input  logic                res_free,
  output logic                res_load,
  output res_t                res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = AW + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_DEL, S_DCHK1, S_DCHK2, S_DLAST, S_DPAR,
    S_UP, S_UPCMP, S_DOWN, S_DCH, S_DDEC, S_PLACE, S_ROOT, S_FIN
  } state_t;

  state_t              state;
  logic [CW-1:0]       cnt;
  logic [AW-1:0]       slot;
  logic [AW-1:0]       p;
  logic [KEY_BITS-1:0] mk;
  logic [7:0]          mh;
  logic [2:0]          j;
  logic [1:0]          status;

  // Memories
  logic [KEY_BITS-1:0] hkey [CAPACITY];
  logic [7:0]          hhnd [CAPACITY];
  logic [AW-1:0]       ptab [256];

  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [7:0]          rd_hnd;
  logic [AW-1:0]       rd_idx;
  logic [AW-1:0]       pt_rd;

  logic                hw_en;
  logic [AW-1:0]       hw_addr;
  logic [KEY_BITS-1:0] hw_key;
  logic [7:0]          hw_hnd;
  logic                pw_en;
  logic [7:0]          pw_addr;

  logic [AW-1:0]       parent;
  logic [AW-1:0]       p_parent;
  logic [FW-1:0]       first_c;
  logic [FW-1:0]       cj;
  logic [FW-1:0]       cnt_f;
  logic [CW-1:0]       last;

  trk_ctl_t            trk;
  logic [KEY_BITS-1:0] best_key;
  logic [7:0]          best_hnd;
  logic [AW-1:0]       best_idx;

  // Index arithmetic
  assign parent   = AW'((slot - AW'(1)) >> 2);
  assign p_parent = AW'((p - AW'(1)) >> 2);
  assign first_c  = (FW'(slot) << 2) + FW'(1);
  assign cj       = first_c + FW'(j);
  assign cnt_f    = FW'(cnt);
  assign last     = cnt - CW'(1);

  // Memory ports: one read, one write per memory
  always_ff @(posedge clk) begin
    rd_key <= hkey[rd_addr];
    rd_hnd <= hhnd[rd_addr];
    rd_idx <= rd_addr;
    pt_rd  <= ptab[mh];
    if (hw_en) begin
      hkey[hw_addr] <= hw_key;
      hhnd[hw_addr] <= hw_hnd;
    end
    if (pw_en) begin
      ptab[pw_addr] <= hw_addr;
    end
  end

  qmh_best #(.KEY_BITS(KEY_BITS), .AW(AW)) u_best (
    .clk      (clk),
    .ctl      (trk),
    .key      (rd_key),
    .hnd      (rd_hnd),
    .idx      (rd_idx),
    .best_key (best_key),
    .best_hnd (best_hnd),
    .best_idx (best_idx)
  );

  // Read address, writes and tracker control per state
  always_comb begin
    rd_addr   = '0;
    hw_en     = 1'b0;
    hw_addr   = slot;
    hw_key    = mk;
    hw_hnd    = mh;
    pw_en     = 1'b0;
    pw_addr   = mh;
    trk.load  = 1'b0;
    trk.first = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      S_DCHK1: rd_addr = pt_rd;
      S_DCHK2: rd_addr = AW'(last);
      S_DLAST: rd_addr = p_parent;
      S_UP:    rd_addr = parent;
      S_UPCMP: begin
        rd_addr = parent;
        if (mk < rd_key) begin
          hw_en   = 1'b1;
          hw_key  = rd_key;
          hw_hnd  = rd_hnd;
          pw_en   = 1'b1;
          pw_addr = rd_hnd;
        end
      end
      S_DOWN:  rd_addr = AW'(first_c);
      S_DCH: begin
        trk.load  = 1'b1;
        trk.first = (j == 3'd1);
        rd_addr   = AW'(cj);
      end
      S_DDEC: begin
        if (!(mk < best_key)) begin
          hw_en   = 1'b1;
          hw_key  = best_key;
          hw_hnd  = best_hnd;
          pw_en   = 1'b1;
          pw_addr = best_hnd;
        end
      end
      S_PLACE: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
      end
      S_FIN:   res_load = res_free;
      default: ;
    endcase
  end

  assign idle = (state == S_IDLE);

  // Result fields, root read back after the operation
  always_comb begin
    res.status     = status;
    res.count      = 9'(cnt);
    res.empty_res  = (cnt == '0);
    res.min_key    = res.empty_res ? 32'd0 : 32'(rd_key);
    res.min_handle = res.empty_res ? 8'd0 : rd_hnd;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      status <= ST_DONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mk     <= key;
            mh     <= handle;
            status <= ST_DONE;
            state  <= (cmd == CMD_DELETE) ? S_DEL : S_INS;
          end
        end
        S_INS: begin
          if (cnt >= CW'(CAPACITY)) begin
            status <= ST_FULL;
            state  <= S_ROOT;
          end else begin
            slot  <= AW'(cnt);
            cnt   <= cnt + CW'(1);
            state <= S_UP;
          end
        end
        S_DEL: begin
          if (cnt == '0) begin
            status <= ST_EMPTY;
            state  <= S_ROOT;
          end else begin
            state <= S_DCHK1;
          end
        end
        // Unplaced handles hold stale or unset entries and end in a miss arm
        S_DCHK1: begin
          p <= pt_rd;
          if (CW'(pt_rd) < cnt) begin
            state <= S_DCHK2;
          end else begin
            status <= ST_MISS;
            state  <= S_ROOT;
          end
        end
        S_DCHK2: begin
          if (rd_hnd == mh) begin
            cnt   <= last;
            state <= (CW'(p) == last) ? S_ROOT : S_DLAST;
          end else begin
            status <= ST_MISS;
            state  <= S_ROOT;
          end
        end
        S_DLAST: begin
          mk    <= rd_key;
          mh    <= rd_hnd;
          slot  <= p;
          state <= (p == '0) ? S_DOWN : S_DPAR;
        end
        S_DPAR:  state <= (mk < rd_key) ? S_UP : S_DOWN;
        S_UP:    state <= (slot == '0) ? S_PLACE : S_UPCMP;
        S_UPCMP: begin
          if (mk < rd_key) begin
            slot  <= parent;
            state <= S_UP;
          end else begin
            state <= S_PLACE;
          end
        end
        S_DOWN: begin
          if (first_c >= cnt_f) begin
            state <= S_PLACE;
          end else begin
            j     <= 3'd1;
            state <= S_DCH;
          end
        end
        S_DCH: begin
          if (j < 3'd4 && cj < cnt_f) begin
            j <= j + 3'd1;
          end else begin
            state <= S_DDEC;
          end
        end
        S_DDEC: begin
          if (mk < best_key) begin
            state <= S_PLACE;
          end else begin
            slot  <= best_idx;
            state <= S_DOWN;
          end
        end
        S_PLACE: state <= S_ROOT;
        S_ROOT:  state <= S_FIN;
        S_FIN:   if (res_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
    else $error("entry count jumped");
  a_wr_range: assert property (@(posedge clk) disable iff (rst) hw_en |-> CW'(hw_addr) < cnt)
    else $error("heap write beyond held entries");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (res_load && status == ST_FULL) |-> cnt == CW'(CAPACITY))
    else $error("full status with room left");

endmodule

[hw/rtl/quaternary_min_heap_queue.sv]
// ---------------------------------------------------------------------------
// quaternary_min_heap_queue
// Fixed-capacity 4-ary min-heap of keyed handles with insert and delete.
// ---------------------------------------------------------------------------
// One operation at a time. An insert reads one parent per level it rises;
// a delete reads one parent per level up or each existing child per level
// down, one at a time through the single read port of the heap memory. The
// next operation is taken as soon as the result is in the output register.
// Slots never written are never read for a result.
module quaternary_min_heap_queue
  import qmh_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  qmh_req_if.sink   req,
  qmh_res_if.source res
);

  logic res_free;
  logic res_load;
  logic idle;
  res_t res_d;
  res_t res_q;

  assign req.ready = idle;
  assign res_free  = !res.valid || res.ready;

  qmh_core #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid && req.ready),
    .cmd      (req.command),
    .key      (KEY_BITS'(req.key)),
    .handle   (req.handle),
    .idle     (idle),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res_d)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res.status     = res_q.status;
  assign res.min_key    = res_q.min_key;
  assign res.min_handle = res_q.min_handle;
  assign res.count      = res_q.count;
  assign res.empty_res  = res_q.empty_res;

endmodule

[verif/qmh_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qmh_checker
// Watches the request and result channels of the heap queue, keeps a shadow
// 4-ary min-heap, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module qmh_checker
  import qmh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  qmh_req_if   req,
  qmh_res_if   res,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   held
);

  localparam int CAP = 256;

  logic [31:0] sh_key [CAP];
  logic [7:0]  sh_hdl [CAP];
  logic [7:0]  slot_of [256];
  int          n_held;
  res_t        want_q [$];

  // Write one entry to a slot and track its handle.
  function automatic void put(int slot, logic [31:0] k, logic [7:0] h);
    sh_key[slot] = k;
    sh_hdl[slot] = h;
    slot_of[h] = slot[7:0];
  endfunction

  function automatic int rise(int slot, logic [31:0] k);
    int up;
    while (slot > 0) begin
      up = (slot - 1) >> 2;
      if (!(k < sh_key[up])) break;
      put(slot, sh_key[up], sh_hdl[up]);
      slot = up;
    end
    return slot;
  endfunction

  function automatic int sink_down(int slot, logic [31:0] k);
    int first;
    int best;
    forever begin
      first = slot * 4 + 1;
      if (first >= n_held) break;
      best = first;
      for (int j = 1; j < 4; j++)
        if (first + j < n_held && sh_key[first + j] < sh_key[best]) best = first + j;
      if (k < sh_key[best]) break;
      put(slot, sh_key[best], sh_hdl[best]);
      slot = best;
    end
    return slot;
  endfunction

  // Apply one operation to the shadow heap and return the expected result.
  function automatic res_t heap_op(logic cmd, logic [31:0] k, logic [7:0] h);
    res_t r;
    int pos;
    int last;
    int slot;
    logic [31:0] mk;
    logic [7:0] mh;
    r.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (n_held >= CAP) r.status = ST_FULL;
      else begin
        slot = n_held;
        n_held++;
        slot = rise(slot, k);
        put(slot, k, h);
      end
    end else if (n_held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pos = slot_of[h];
      if (pos >= n_held || sh_hdl[pos] != h) r.status = ST_MISS;
      else begin
        n_held--;
        last = n_held;
        if (pos != last) begin
          mk = sh_key[last];
          mh = sh_hdl[last];
          if (pos > 0 && mk < sh_key[(pos - 1) >> 2]) slot = rise(pos, mk);
          else slot = sink_down(pos, mk);
          put(slot, mk, mh);
        end
      end
    end
    r.empty_res  = (n_held == 0);
    r.min_key    = r.empty_res ? '0 : sh_key[0];
    r.min_handle = r.empty_res ? '0 : sh_hdl[0];
    r.count      = n_held[8:0];
    return r;
  endfunction

  // Predict on request transfers, compare on result transfers.
  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      n_held = 0;
      want_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      for (int i = 0; i < CAP; i++) begin
        sh_key[i] = '0;
        sh_hdl[i] = '0;
      end
      for (int i = 0; i < 256; i++) slot_of[i] = '0;
    end else begin
      if (req.valid && req.ready) want_q.push_back(heap_op(req.command, req.key, req.handle));
      if (res.valid && res.ready) begin
        results_seen <= results_seen + 1;
        if (want_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (res.status !== w.status || res.min_key !== w.min_key ||
              res.min_handle !== w.min_handle || res.count !== w.count ||
              res.empty_res !== w.empty_res) begin
            fail_count <= fail_count + 1;
            if (res.status !== w.status)
              $error("status: expected %0d, got %0d", w.status, res.status);
            if (res.min_key !== w.min_key)
              $error("min_key: expected %0h, got %0h", w.min_key, res.min_key);
            if (res.min_handle !== w.min_handle)
              $error("min_handle: expected %0d, got %0d", w.min_handle, res.min_handle);
            if (res.count !== w.count)
              $error("count: expected %0d, got %0d", w.count, res.count);
            if (res.empty_res !== w.empty_res)
              $error("empty_res: expected %0d, got %0d", w.empty_res, res.empty_res);
          end
        end
      end
    end
    pending = want_q.size();
    held = n_held;
  end

endmodule

[verif/quaternary_min_heap_queue_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternary_min_heap_queue_tb
// Drives inserts and deletes into the heap queue under varying back-pressure
// and takes the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module quaternary_min_heap_queue_tb;
  import qmh_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending, seen, held;
  int   cycles = 0;
  int   send_idle = 0, recv_idle = 0;
  int   n_sent = 0;
  logic [7:0] live_h [$];

  qmh_req_if req ();
  qmh_res_if res ();

  quaternary_min_heap_queue uut (.clk(clk), .rst(rst), .req(req), .res(res));

  qmh_checker chk (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .fail_count(fails), .pending(pending), .results_seen(seen), .held(held)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("quaternary_min_heap_queue_tb failed");
      $finish;
    end
  end

  // Result-side stalls
  initial res.ready = 1'b0;
  always @(negedge clk) res.ready <= !rst && ($urandom_range(99) >= recv_idle);

  // Present one operation and hold it until transferred; valid stays up
  // until the next call either idles or presents the next operation.
  task automatic send_op(logic cmd, logic [31:0] k, logic [7:0] h);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.key     <= k;
    req.handle  <= h;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (cmd == CMD_INSERT && held <= 256) live_h.push_back(h);
  endtask

  // Inserts narrow or full keys by fill bias; deletes held handles, some misses.
  task automatic random_op(int fill_bias);
    logic [31:0] k;
    int i;
    if ($urandom_range(99) < fill_bias) begin
      k = $urandom_range(3) == 0 ? $urandom : $urandom_range(40);
      send_op(CMD_INSERT, k, 8'($urandom));
    end else if (live_h.size() > 0 && $urandom_range(9) != 0) begin
      i = $urandom_range(live_h.size() - 1);
      send_op(CMD_DELETE, $urandom, live_h[i]);
      live_h.delete(i);
    end else begin
      send_op(CMD_DELETE, $urandom, 8'($urandom));
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.command = CMD_INSERT;
    req.key = '0;
    req.handle = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty delete, extremes, duplicates, root and last-slot deletes
    send_op(CMD_DELETE, 32'h0, 8'd0);
    send_op(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_op(CMD_INSERT, 32'h0, 8'h00);
    send_op(CMD_INSERT, 32'h5555_AAAA, 8'h55);
    send_op(CMD_INSERT, 32'hAAAA_5555, 8'hAA);
    send_op(CMD_INSERT, 32'h0, 8'h01);
    send_op(CMD_INSERT, 32'h7, 8'h55);
    send_op(CMD_DELETE, 32'hFFFF_FFFF, 8'h00);
    send_op(CMD_DELETE, 32'h0, 8'h55);
    send_op(CMD_DELETE, 32'h0, 8'h33);
    send_op(CMD_DELETE, 32'h0, 8'h55);
    send_op(CMD_DELETE, 32'h0, 8'h01);
    send_op(CMD_DELETE, 32'h0, 8'hAA);
    send_op(CMD_DELETE, 32'h0, 8'hFF);
    send_op(CMD_DELETE, 32'h0, 8'hFF);
    live_h.delete();

    // Fill past capacity to reach the full refusal, then delete 256 recorded handles
    for (int i = 0; i < 258; i++) send_op(CMD_INSERT, $urandom_range(60), i[7:0]);
    for (int i = 0; i < 256; i++) begin
      int j;
      j = $urandom_range(live_h.size() - 1);
      send_op(CMD_DELETE, 32'h0, live_h[j]);
      live_h.delete(j);
    end

    // Random phases with different idling on each side
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 88 : 0;
      recv_idle = (ph == 0) ? 88 : (ph == 1) ? 18 : 0;
      for (int n = 0; n < 210; n++) random_op((n % 105) < 70 ? 70 : 30);
    end
    req.valid <= 1'b0;

    while (pending > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d operations and checked %0d results across three stall mixes,",
             n_sent, seen);
    $display("including full, empty, miss, duplicate and root cases.");
    if (fails == 0) $display("quaternary_min_heap_queue_tb passed");
    else $display("quaternary_min_heap_queue_tb failed");
    $finish;
  end

endmodule
